>>> rtl/core/tnc2_header_parser_defines.svh
// Shared assertion macros for the header parser.
`ifndef TNC2_HEADER_PARSER_DEFINES_SVH
`define TNC2_HEADER_PARSER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TNC2HP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define TNC2HP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tnc2hp_pkg.sv
package tnc2hp_pkg;

    localparam int MAX_LEN_DEF = 2048;

    localparam int CALL_W = 6;
    localparam int POS_W  = 11;
    localparam int LEN_W  = 12;
    localparam int LEN_CAP = 2049;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CALLSIGN_MAX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALLSIGN_MIN = 1'd1;

    localparam logic [CALL_W-1:0] CALLSIGN_MAX_RST = 6'd9;
    localparam logic [CALL_W-1:0] CALLSIGN_MIN_RST = 6'd1;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_NO_GT      = 3'd1;
    localparam logic [2:0] ERR_NO_DST     = 3'd2;
    localparam logic [2:0] ERR_SRC_LEN    = 3'd3;
    localparam logic [2:0] ERR_NO_PAYLOAD = 3'd4;
    localparam logic [2:0] ERR_DST_LONG   = 3'd5;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [POS_W-1:0] path_len;
        logic             last_byte;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        error_code;
        logic [CALL_W-1:0] src_call_len;
        logic [POS_W-1:0]  dst_base_end;
        logic [POS_W-1:0]  dst_full_end;
        logic [POS_W-1:0]  dst_call_len;
        logic [POS_W-1:0]  info_offset;
    } t_out_item;

    typedef struct packed {
        logic              gt_seen;
        logic [CALL_W-1:0] gt_pos;
        logic              scan_done;
        logic [POS_W-1:0]  base_mark;
        logic [POS_W-1:0]  end_mark;
        logic [LEN_W-1:0]  pkt_len;
        logic [POS_W-1:0]  path_len;
    } t_summary;

    typedef struct packed {
        logic [CALL_W-1:0] callsign_max;
        logic [CALL_W-1:0] callsign_min;
    } t_cfg;

endpackage

>>> rtl/core/tnc2_header_parser.sv
// TNC2 APRS header parser.
// Input channel: one packet byte per word (i_in_valid / o_in_ready / i_in_data),
// with path_len held for the packet and last_byte marking its final byte.
// Output channel: one result word per packet (o_out_valid / i_out_ready /
// o_out_data) with accept flag, error code and header field offsets.
// Configuration channel: i_cfg_valid / o_cfg_ready, index 0 callsign_max,
// index 1 callsign_min; always ready, write only while no packet is in flight.
// Throughput: one byte per cycle while the queue is not full; the scanner keeps per-packet
// marks and hands a summary into a two-entry queue on the last byte.
// When the last byte is taken its summary is written into the queue; it is then popped
// into the checking stage's output register, which drives o_out_valid.
// When the receiver stalls, the output register holds its word, the queue
// fills, and o_in_ready drops only once the queue is full.
// Reset clears the scanner marks, empties the queue and output register, and
// loads callsign_max = 9, callsign_min = 1.
module tnc2_header_parser
    import tnc2hp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     q_full;
    logic     q_valid;
    logic     push;
    logic     pop;
    t_summary front_sum;
    t_summary back_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.callsign_max <= CALLSIGN_MAX_RST;
            r_cfg.callsign_min <= CALLSIGN_MIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CALLSIGN_MAX: r_cfg.callsign_max <= i_cfg_data;
                REG_CALLSIGN_MIN: r_cfg.callsign_min <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tnc2hp_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_summary  (front_sum)
    );

    tnc2hp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sum),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (back_sum)
    );

    tnc2hp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .i_summary   (back_sum),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/tnc2hp_front.sv
module tnc2hp_front
    import tnc2hp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_summary o_summary
);

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int CW    = (IDX_W > LEN_W) ? IDX_W : LEN_W;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_BASE = 2'd1;
    localparam logic [1:0] PH_SSID = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [IDX_W-1:0]  r_idx,    n_idx;
    logic [1:0]        r_phase,  n_phase;
    logic [CALL_W-1:0] r_gt_pos, n_gt_pos;
    logic [POS_W-1:0]  r_base,   n_base;
    logic [POS_W-1:0]  r_end,    n_end;

    logic          accept;
    logic [CW-1:0] i_ext;
    logic [CW-1:0] plen_ext;
    logic [CW-1:0] nidx_ext;
    logic          in_pkt;
    logic          is_end;
    logic [7:0]    b;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && i_in_data.last_byte;

    assign b        = i_in_data.data_byte;
    assign i_ext    = CW'(r_idx);
    assign plen_ext = CW'(i_in_data.path_len);
    assign in_pkt   = i_ext < plen_ext;
    assign is_end   = (b == CH_COMMA) || (b == CH_COLON);

    always_comb begin
        n_idx    = r_idx;
        n_phase  = r_phase;
        n_gt_pos = r_gt_pos;
        n_base   = r_base;
        n_end    = r_end;
        if (r_idx < IDX_W'(MAX_LEN)) begin
            n_idx = r_idx + IDX_W'(1);
            unique case (r_phase)
                PH_WAIT: begin
                    if (in_pkt && i_ext <= CW'(i_cfg.callsign_max) && b == CH_GT) begin
                        n_phase  = PH_BASE;
                        n_gt_pos = r_idx[CALL_W-1:0];
                    end
                end
                PH_BASE: begin
                    if (!in_pkt) begin
                        n_base  = i_in_data.path_len;
                        n_end   = i_in_data.path_len;
                        n_phase = PH_DONE;
                    end else if (b == CH_DASH || is_end) begin
                        n_base = i_ext[POS_W-1:0];
                        if (is_end) begin
                            n_end   = i_ext[POS_W-1:0];
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SSID;
                        end
                    end
                end
                PH_SSID: begin
                    if (!in_pkt) begin
                        n_end   = i_in_data.path_len;
                        n_phase = PH_DONE;
                    end else if (is_end) begin
                        n_end   = i_ext[POS_W-1:0];
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign nidx_ext = CW'(n_idx);

    always_comb begin
        o_summary.gt_seen   = (n_phase != PH_WAIT);
        o_summary.gt_pos    = n_gt_pos;
        o_summary.scan_done = (n_phase == PH_DONE);
        o_summary.base_mark = n_base;
        o_summary.end_mark  = n_end;
        o_summary.pkt_len   = (nidx_ext > CW'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                        : nidx_ext[LEN_W-1:0];
        o_summary.path_len  = i_in_data.path_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_idx    <= '0;
            r_phase  <= PH_WAIT;
            r_gt_pos <= '0;
            r_base   <= '0;
            r_end    <= '0;
        end else if (accept) begin
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_gt_pos <= n_gt_pos;
            r_base   <= n_base;
            r_end    <= n_end;
        end
    end

endmodule

>>> rtl/core/tnc2hp_queue.sv
`include "tnc2_header_parser_defines.svh"

module tnc2hp_queue
    import tnc2hp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    output logic     o_full,
    output logic     o_valid,
    input  logic     i_pop,
    output t_summary o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_summary         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    `TNC2HP_ASSERT_NOW(a_no_overflow, i_push, !o_full, "push into full queue")
    `TNC2HP_ASSERT_NOW(a_no_underflow, i_pop, o_valid, "pop from empty queue")
    `TNC2HP_ASSERT_NEXT(a_count_up, (i_push && !i_pop), (r_count == $past(r_count) + CNT_W'(1)),
        "queue count did not advance on push")

endmodule

>>> rtl/core/tnc2hp_back.sv
`include "tnc2_header_parser_defines.svh"

module tnc2hp_back
    import tnc2hp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    output logic      o_pop,
    input  t_summary  i_summary,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;

    logic [POS_W-1:0] base;
    logic [POS_W-1:0] full;
    logic [LEN_W-1:0] gp1;
    logic [LEN_W-1:0] plen1;
    logic [LEN_W-1:0] full12;
    logic [LEN_W-1:0] dst_len;
    logic [2:0]       code;

    assign o_pop = i_q_valid && (!r_valid || i_out_ready);

    assign base    = i_summary.scan_done ? i_summary.base_mark : i_summary.path_len;
    assign full    = i_summary.scan_done ? i_summary.end_mark  : i_summary.path_len;
    assign gp1     = LEN_W'(i_summary.gt_pos) + LEN_W'(1);
    assign plen1   = LEN_W'(i_summary.path_len) + LEN_W'(1);
    assign full12  = LEN_W'(full);
    assign dst_len = full12 - gp1;

    always_comb begin
        priority if (!i_summary.gt_seen) begin
            code = ERR_NO_GT;
        end else if (gp1 >= i_summary.pkt_len) begin
            code = ERR_NO_DST;
        end else if (i_summary.gt_pos > i_cfg.callsign_max
                     || i_summary.gt_pos < i_cfg.callsign_min) begin
            code = ERR_SRC_LEN;
        end else if (plen1 >= i_summary.pkt_len) begin
            code = ERR_NO_PAYLOAD;
        end else if (full12 < gp1 || dst_len > LEN_W'(i_cfg.callsign_max)) begin
            code = ERR_DST_LONG;
        end else begin
            code = ERR_OK;
        end
    end

    always_comb begin
        n_data            = '0;
        n_data.accepted   = (code == ERR_OK);
        n_data.error_code = code;
        if (code == ERR_OK) begin
            n_data.src_call_len = i_summary.gt_pos;
            n_data.dst_base_end = base;
            n_data.dst_full_end = full;
            n_data.dst_call_len = dst_len[POS_W-1:0];
            n_data.info_offset  = plen1[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    `TNC2HP_ASSERT_NOW(a_accept_ok, r_valid, (r_data.accepted == (r_data.error_code == ERR_OK)),
        "accepted flag disagrees with error code")
    `TNC2HP_ASSERT_NOW(a_err_zero, (r_valid && r_data.error_code != ERR_OK),
        (r_data.info_offset == '0 && r_data.dst_full_end == '0 && r_data.src_call_len == '0),
        "error word carries field offsets")
    `TNC2HP_ASSERT_NEXT(a_load, o_pop, r_valid, "popped summary not held in output register")

endmodule
